/* rtl/core/mwbsa_pkg.sv */
// Shared types and constants for the multi-word bitmap slot allocator.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps

package mwbsa_pkg;

  localparam int unsigned MAX_HEAPS_DEF      = 8;
  localparam int unsigned SLOTS_PER_HEAP_DEF = 64;

  localparam int unsigned HEAP_W   = 3;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CMP_W    = 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_DOUBLE = 2'd2,
    ST_NOHEAP = 2'd3
  } status_e;

  typedef struct packed {
    logic              is_free;
    logic [HEAP_W-1:0] heap;
    logic [SLOT_W-1:0] slot;
    logic              slot_oob;
  } cmd_t;

endpackage

/* rtl/core/mwbsa_front.sv */
// Front end: takes requests from the input channel and decodes them into commands.
// Depends on mwbsa_pkg.
`timescale 1ns / 1ps

module mwbsa_front #(
  parameter int unsigned SLOTS_PER_HEAP = mwbsa_pkg::SLOTS_PER_HEAP_DEF
) (
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            mode_i,
  input  logic [mwbsa_pkg::HEAP_W-1:0]    free_heap_i,
  input  logic [mwbsa_pkg::SLOT_W-1:0]    free_slot_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output mwbsa_pkg::cmd_t                 cmd_o
);

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cmd_o.is_free  = mode_i;
    cmd_o.heap     = free_heap_i;
    cmd_o.slot     = free_slot_i;
    cmd_o.slot_oob = mwbsa_pkg::CMP_W'(free_slot_i) >= mwbsa_pkg::CMP_W'(SLOTS_PER_HEAP);
  end

endmodule

/* rtl/core/mwbsa_queue.sv */
// Two-entry command queue between front end and back end.
// Depends on mwbsa_pkg.
`timescale 1ns / 1ps

module mwbsa_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mwbsa_pkg::cmd_t push_cmd_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output mwbsa_pkg::cmd_t pop_cmd_o
);

  mwbsa_pkg::cmd_t entry_q [2];
  logic [1:0]      count_q, count_d;
  logic            wr_ptr_q, rd_ptr_q;
  logic            do_pop;

  assign full_o    = count_q == 2'd2;
  assign valid_o   = count_q != 2'd0;
  assign do_pop    = pop_i && valid_o;
  assign pop_cmd_o = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* rtl/core/mwbsa_back.sv */
// Back end: heap selection, free-mask memory, lowest-bit pick and result register.
// Depends on mwbsa_pkg.
`timescale 1ns / 1ps

module mwbsa_back #(
  parameter int unsigned MAX_HEAPS      = mwbsa_pkg::MAX_HEAPS_DEF,
  parameter int unsigned SLOTS_PER_HEAP = mwbsa_pkg::SLOTS_PER_HEAP_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  output logic                              q_pop_o,
  input  mwbsa_pkg::cmd_t                   cmd_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mwbsa_pkg::HEAP_W-1:0]      got_heap_o,
  output logic [mwbsa_pkg::SLOT_W-1:0]      got_slot_o,
  output logic [mwbsa_pkg::STATUS_W-1:0]    status_o
);

  localparam int unsigned IDX_W  = (MAX_HEAPS > 1) ? $clog2(MAX_HEAPS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_HEAPS + 1);
  localparam int unsigned SLOT_W = $clog2(SLOTS_PER_HEAP);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e                    state_q, state_d;
  logic [CNT_W-1:0]          open_cnt_q;
  logic [MAX_HEAPS-1:0]      nz_q, open_vec, cand;
  logic [SLOTS_PER_HEAP-1:0] mem_q [MAX_HEAPS];
  logic [SLOTS_PER_HEAP-1:0] rd_q, word, wr_data;
  logic [IDX_W-1:0]          idx_d, idx_q, first_idx;
  logic                      fresh_d, fresh_q, err_d, err_q, free_q;
  mwbsa_pkg::status_e        err_st_d, err_st_q;
  logic [SLOT_W-1:0]         slot_q, pos;
  logic                      go, wr_en, heap_ok, can_open;
  logic [mwbsa_pkg::HEAP_W-1:0]   res_heap;
  logic [mwbsa_pkg::SLOT_W-1:0]   res_slot;
  mwbsa_pkg::status_e        res_st;
  logic                      out_valid_q;
  logic [mwbsa_pkg::HEAP_W-1:0]   got_heap_q;
  logic [mwbsa_pkg::SLOT_W-1:0]   got_slot_q;
  mwbsa_pkg::status_e        status_q;

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;
  assign go      = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    for (int i = 0; i < MAX_HEAPS; i++) begin
      open_vec[i] = mwbsa_pkg::CMP_W'(i) < mwbsa_pkg::CMP_W'(open_cnt_q);
    end
    cand = nz_q & open_vec;
    first_idx = '0;
    for (int i = MAX_HEAPS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    can_open = mwbsa_pkg::CMP_W'(open_cnt_q) < mwbsa_pkg::CMP_W'(MAX_HEAPS);
    heap_ok  = mwbsa_pkg::CMP_W'(cmd_i.heap) < mwbsa_pkg::CMP_W'(open_cnt_q);
    idx_d    = IDX_W'(cmd_i.heap);
    fresh_d  = 1'b0;
    err_d    = 1'b0;
    err_st_d = mwbsa_pkg::ST_OK;
    if (!cmd_i.is_free) begin
      if (|cand) begin
        idx_d = first_idx;
      end else if (can_open) begin
        idx_d   = IDX_W'(open_cnt_q);
        fresh_d = 1'b1;
      end else begin
        err_d    = 1'b1;
        err_st_d = mwbsa_pkg::ST_FULL;
      end
    end else if (!heap_ok) begin
      err_d    = 1'b1;
      err_st_d = mwbsa_pkg::ST_NOHEAP;
    end else if (cmd_i.slot_oob) begin
      err_d    = 1'b1;
      err_st_d = mwbsa_pkg::ST_DOUBLE;
    end
  end

  always_comb begin
    word = fresh_q ? '1 : rd_q;
    pos  = '0;
    for (int i = SLOTS_PER_HEAP - 1; i >= 0; i--) begin
      if (word[i]) begin
        pos = SLOT_W'(i);
      end
    end
    wr_en    = 1'b0;
    wr_data  = word;
    res_heap = '0;
    res_slot = '0;
    res_st   = err_st_q;
    if (!err_q) begin
      if (!free_q) begin
        wr_en    = go;
        wr_data  = word & ~(SLOTS_PER_HEAP'(1) << pos);
        res_heap = mwbsa_pkg::HEAP_W'(idx_q);
        res_slot = mwbsa_pkg::SLOT_W'(pos);
        res_st   = mwbsa_pkg::ST_OK;
      end else if (word[slot_q]) begin
        res_st = mwbsa_pkg::ST_DOUBLE;
      end else begin
        wr_en   = go;
        wr_data = word | (SLOTS_PER_HEAP'(1) << slot_q);
        res_st  = mwbsa_pkg::ST_OK;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      open_cnt_q  <= '0;
      nz_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        nz_q[idx_q] <= |wr_data;
      end
      if (go && fresh_q && !err_q) begin
        open_cnt_q <= open_cnt_q + CNT_W'(1);
      end
      if (go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[idx_q] <= wr_data;
    end
    if (q_pop_o) begin
      rd_q <= mem_q[idx_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      idx_q    <= idx_d;
      fresh_q  <= fresh_d;
      err_q    <= err_d;
      err_st_q <= err_st_d;
      free_q   <= cmd_i.is_free;
      slot_q   <= SLOT_W'(cmd_i.slot);
    end
    if (go) begin
      got_heap_q <= res_heap;
      got_slot_q <= res_slot;
      status_q   <= res_st;
    end
  end

  assign out_valid_o = out_valid_q;
  assign got_heap_o  = got_heap_q;
  assign got_slot_o  = got_slot_q;
  assign status_o    = status_q;

endmodule

/* rtl/core/multi_word_bitmap_slot_allocator_unit.sv */
// Top level of the multi-word bitmap slot allocator.
// Depends on mwbsa_pkg, mwbsa_front, mwbsa_queue and mwbsa_back.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request: mode_i 0 allocates
//   the lowest free slot of the first open heap with room, opening a new heap when
//   none has room; mode_i 1 frees slot free_slot_i of heap free_heap_i.
//   Output channel (out_valid_o/out_ready_i) returns exactly one result per request:
//   got_heap_o, got_slot_o and status_o (ok, full, double free, heap not open).
//   Each request passes through the queue, the back end's read of the free-mask
//   memory, its pick-and-write-back state and the result register; the back end
//   takes no new request until it has written back the one before.
//   A two-entry queue buffers requests, so the input stays ready while the back
//   end works or while a result waits to be taken, as long as the queue is not full.
//   Reset closes every heap and empties queue and output register; the mask
//   memory is not cleared, as a heap's mask is written when the heap opens.
//   When the receiver stalls, the result holds, the back end waits, and the input
//   drops ready once the queue is full.
`timescale 1ns / 1ps

module multi_word_bitmap_slot_allocator_unit #(
  parameter int unsigned MAX_HEAPS      = mwbsa_pkg::MAX_HEAPS_DEF,
  parameter int unsigned SLOTS_PER_HEAP = mwbsa_pkg::SLOTS_PER_HEAP_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [mwbsa_pkg::HEAP_W-1:0]      free_heap_i,
  input  logic [mwbsa_pkg::SLOT_W-1:0]      free_slot_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mwbsa_pkg::HEAP_W-1:0]      got_heap_o,
  output logic [mwbsa_pkg::SLOT_W-1:0]      got_slot_o,
  output logic [mwbsa_pkg::STATUS_W-1:0]    status_o
);

  mwbsa_pkg::cmd_t push_cmd, pop_cmd;
  logic            push, q_full, q_valid, q_pop;

  mwbsa_front #(
    .SLOTS_PER_HEAP(SLOTS_PER_HEAP)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .free_heap_i(free_heap_i),
    .free_slot_i(free_slot_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  mwbsa_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (q_full),
    .valid_o   (q_valid),
    .pop_i     (q_pop),
    .pop_cmd_o (pop_cmd)
  );

  mwbsa_back #(
    .MAX_HEAPS     (MAX_HEAPS),
    .SLOTS_PER_HEAP(SLOTS_PER_HEAP)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .cmd_i      (pop_cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .got_heap_o (got_heap_o),
    .got_slot_o (got_slot_o),
    .status_o   (status_o)
  );

endmodule
